### hw/rtl/bezier_curve_segmenter_macros.svh
// assertion macros for the bezier curve segmenter
`ifndef BEZIER_CURVE_SEGMENTER_MACROS_SVH
`define BEZIER_CURVE_SEGMENTER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define BCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bcs_pkg.sv
// types, constants and helpers shared by the bezier curve segmenter
package bcs_pkg;

   localparam int PT_W  = 16;
   localparam int OUT_W = 20;
   localparam int CFG_W = 7;

   localparam logic [CFG_W-1:0] SEG_RESET = 7'd25;

   localparam logic signed [31:0] OUT_MAX = 32'sd524287;
   localparam logic signed [31:0] OUT_MIN = -32'sd524288;

   typedef struct packed {
      logic signed [PT_W-1:0] start_x;
      logic signed [PT_W-1:0] start_y;
      logic signed [PT_W-1:0] control_x;
      logic signed [PT_W-1:0] control_y;
      logic signed [PT_W-1:0] end_x;
      logic signed [PT_W-1:0] end_y;
   } bcs_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] from_x;
      logic signed [OUT_W-1:0] from_y;
      logic signed [OUT_W-1:0] to_x;
      logic signed [OUT_W-1:0] to_y;
      logic                    is_last;
   } bcs_rsp_type;

   // travels alongside each sample through the pipeline
   typedef struct packed {
      logic                   valid;
      logic                   first;
      logic                   last;
      logic signed [PT_W-1:0] start_x;
      logic signed [PT_W-1:0] start_y;
   } bcs_ctrl_type;

   function automatic logic signed [OUT_W-1:0] bcs_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      begin
         r = v;
         if (v > OUT_MAX) begin
            r = OUT_MAX;
         end else if (v < OUT_MIN) begin
            r = OUT_MIN;
         end
         return r[OUT_W-1:0];
      end
   endfunction

endpackage

### hw/rtl/bcs_divider.sv
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
module bcs_divider #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 20,
   parameter int QUO_W = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  bcs_pkg::bcs_ctrl_type in_ctrl,
   input  logic [NUM_W-1:0]      in_num_x,
   input  logic [NUM_W-1:0]      in_num_y,
   input  logic [DEN_W-1:0]      in_den,
   output bcs_pkg::bcs_ctrl_type out_ctrl,
   output logic [QUO_W-1:0]      out_quo_x,
   output logic [QUO_W-1:0]      out_quo_y
);
   import bcs_pkg::*;

   bcs_ctrl_type      ctrl_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_x_ff [QUO_W];
   logic [QUO_W-1:0]  quo_y_ff [QUO_W];
   logic [NUM_W-1:0]  rem_x_ff [QUO_W-1];
   logic [NUM_W-1:0]  rem_y_ff [QUO_W-1];
   logic [DEN_W-1:0]  den_ff   [QUO_W-1];

   for (genvar g = 0; g < QUO_W; g++) begin : g_stage
      localparam int BIT = QUO_W - 1 - g;

      bcs_ctrl_type     ctrl_src;
      logic [NUM_W-1:0] rx_src;
      logic [NUM_W-1:0] ry_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] qx_src;
      logic [QUO_W-1:0] qy_src;
      logic [NUM_W-1:0] den_sh;
      logic [NUM_W:0]   tx;
      logic [NUM_W:0]   ty;
      logic [QUO_W-1:0] qx_in;
      logic [QUO_W-1:0] qy_in;
      logic [NUM_W-1:0] rx_in;
      logic [NUM_W-1:0] ry_in;

      if (g == 0) begin : g_head
         assign ctrl_src = in_ctrl;
         assign rx_src   = in_num_x;
         assign ry_src   = in_num_y;
         assign den_src  = in_den;
         assign qx_src   = '0;
         assign qy_src   = '0;
      end else begin : g_body
         assign ctrl_src = ctrl_ff[g-1];
         assign rx_src   = rem_x_ff[g-1];
         assign ry_src   = rem_y_ff[g-1];
         assign den_src  = den_ff[g-1];
         assign qx_src   = quo_x_ff[g-1];
         assign qy_src   = quo_y_ff[g-1];
      end

      assign den_sh = NUM_W'(den_src) << BIT;
      assign tx     = {1'b0, rx_src} - {1'b0, den_sh};
      assign ty     = {1'b0, ry_src} - {1'b0, den_sh};
      assign qx_in  = qx_src | (QUO_W'(!tx[NUM_W]) << BIT);
      assign qy_in  = qy_src | (QUO_W'(!ty[NUM_W]) << BIT);
      assign rx_in  = tx[NUM_W] ? rx_src : tx[NUM_W-1:0];
      assign ry_in  = ty[NUM_W] ? ry_src : ty[NUM_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[g].valid <= 1'b0;
         end else if (enable) begin
            ctrl_ff[g]  <= ctrl_src;
            quo_x_ff[g] <= qx_in;
            quo_y_ff[g] <= qy_in;
         end
      end

      if (g < QUO_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_x_ff[g] <= rx_in;
               rem_y_ff[g] <= ry_in;
               den_ff[g]   <= den_src;
            end
         end
      end
   end

   assign out_ctrl  = ctrl_ff[QUO_W-1];
   assign out_quo_x = quo_x_ff[QUO_W-1];
   assign out_quo_y = quo_y_ff[QUO_W-1];

endmodule

### hw/rtl/bezier_curve_segmenter.sv
// top level of the bezier curve segmenter
//
// req channel: one item = start, control and end points (16-bit signed pixels).
// rsp channel: one item per line segment, N per curve, from/to points in fixed
//   point with FRAC_BITS fraction bits; is_last marks the final segment.
// csr channel: writes the segment count N (0 acts as 1, above MAX_SEGMENTS
//   acts as MAX_SEGMENTS); the value is sampled when a curve is accepted.
// A sequencer issues sample k = 1..N of the held curve, one per cycle unless
//   the pipeline is frozen, into the weight, product and sum stages and a
//   divider with one quotient bit per stage. Sample 0 is the start point
//   itself and needs no division. The next curve is taken in the cycle of
//   the previous one's last issue, so curves follow back to back.
// Reset clears the sequencer, pipeline valid bits and the output valid and
//   skid flags, and sets N to 25. When rsp_stall holds a segment, one more
//   lands in a skid register and then the pipeline and sample issue freeze;
//   nothing is lost.
`include "bezier_curve_segmenter_macros.svh"

module bezier_curve_segmenter #(
   parameter int MAX_SEGMENTS = 64,
   parameter int FRAC_BITS    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bcs_pkg::bcs_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bcs_pkg::bcs_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [6:0]           csr_wdata
);
   import bcs_pkg::*;

   localparam int K_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int W_W   = 3 * K_W;
   localparam int DEN_W = W_W + 1;
   localparam int QUO_W = FRAC_BITS + 16;
   localparam int NUM_W = QUO_W + DEN_W;
   localparam int V_W   = NUM_W + 1;
   localparam int P_W   = W_W + 17;
   localparam int S_W   = P_W + 2;
   localparam int RES_W = QUO_W + 5;
   localparam logic [RES_W-1:0] Q_BIAS = RES_W'(1) << (FRAC_BITS + 15);

   // configuration
   logic [CFG_W-1:0] seg_count_ff;
   logic [K_W-1:0]   seg_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEG_RESET;
      end else if (csr_valid && csr_ready) begin
         seg_count_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      if (seg_count_ff == '0) begin
         seg_clamped = K_W'(1);
      end else if (seg_count_ff > CFG_W'(MAX_SEGMENTS)) begin
         seg_clamped = K_W'(MAX_SEGMENTS);
      end else begin
         seg_clamped = K_W'(seg_count_ff);
      end
   end

   // sequencer
   logic        pipe_en;
   logic        skid_full_ff;
   logic        seq_busy_ff;
   logic [K_W-1:0] seq_k_ff;
   logic [K_W-1:0] seq_n_ff;
   bcs_req_type seq_pts_ff;
   logic        issue_last;
   logic        req_take;

   assign pipe_en    = !skid_full_ff;
   assign issue_last = (seq_k_ff == seq_n_ff);
   assign req_stall  = seq_busy_ff && !(pipe_en && issue_last);
   assign req_take   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_busy_ff <= 1'b0;
         seq_k_ff    <= K_W'(1);
         seq_n_ff    <= K_W'(1);
      end else if (req_take) begin
         seq_busy_ff <= 1'b1;
         seq_k_ff    <= K_W'(1);
         seq_n_ff    <= seg_clamped;
         seq_pts_ff  <= req_data;
      end else if (seq_busy_ff && pipe_en) begin
         if (issue_last) begin
            seq_busy_ff <= 1'b0;
         end else begin
            seq_k_ff <= seq_k_ff + K_W'(1);
         end
      end
   end

   // stage registers
   bcs_ctrl_type s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff, s4_ctrl_ff;
   bcs_ctrl_type s5_ctrl_ff, s6_ctrl_ff, s7_ctrl_ff;
   bcs_req_type  s1_pts_ff, s2_pts_ff, s3_pts_ff, s4_pts_ff;
   logic [K_W-1:0]   s1_k_ff, s1_u_ff, s1_n_ff;
   logic [K_W-1:0]   s2_k_ff, s2_u_ff, s2_n_ff;
   logic [2*K_W-1:0] s2_u2_ff, s2_k2_ff, s2_n2_ff;
   logic [W_W-1:0]   s3_u3_ff, s3_m1_ff, s3_m2_ff, s3_k3_ff, s3_d_ff;
   logic [W_W-1:0]   s4_w0_ff, s4_w1_ff, s4_w2_ff;
   logic [DEN_W-1:0] s4_dd_ff, s5_dd_ff, s6_dd_ff, s7_dd_ff;
   logic [NUM_W-1:0] s4_bias_ff, s5_bias_ff, s6_bias_ff;
   logic signed [P_W-1:0] s5_px0_ff, s5_px1_ff, s5_px2_ff;
   logic signed [P_W-1:0] s5_py0_ff, s5_py1_ff, s5_py2_ff;
   logic signed [S_W-1:0] s6_sx_ff, s6_sy_ff;
   logic [NUM_W-1:0]      s7_vx_ff, s7_vy_ff;
   logic signed [V_W-1:0] vx_in, vy_in;

   assign vx_in = (V_W'(s6_sx_ff) <<< (FRAC_BITS + 1)) + $signed({1'b0, s6_bias_ff});
   assign vy_in = (V_W'(s6_sy_ff) <<< (FRAC_BITS + 1)) + $signed({1'b0, s6_bias_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff.valid <= 1'b0;
         s2_ctrl_ff.valid <= 1'b0;
         s3_ctrl_ff.valid <= 1'b0;
         s4_ctrl_ff.valid <= 1'b0;
         s5_ctrl_ff.valid <= 1'b0;
         s6_ctrl_ff.valid <= 1'b0;
         s7_ctrl_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         // k, u = n - k
         s1_ctrl_ff.valid   <= seq_busy_ff;
         s1_ctrl_ff.first   <= (seq_k_ff == K_W'(1));
         s1_ctrl_ff.last    <= issue_last;
         s1_ctrl_ff.start_x <= seq_pts_ff.start_x;
         s1_ctrl_ff.start_y <= seq_pts_ff.start_y;
         s1_pts_ff          <= seq_pts_ff;
         s1_k_ff            <= seq_k_ff;
         s1_u_ff            <= seq_n_ff - seq_k_ff;
         s1_n_ff            <= seq_n_ff;
         // squares
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_pts_ff  <= s1_pts_ff;
         s2_k_ff    <= s1_k_ff;
         s2_u_ff    <= s1_u_ff;
         s2_n_ff    <= s1_n_ff;
         s2_u2_ff   <= (2*K_W)'(s1_u_ff) * (2*K_W)'(s1_u_ff);
         s2_k2_ff   <= (2*K_W)'(s1_k_ff) * (2*K_W)'(s1_k_ff);
         s2_n2_ff   <= (2*K_W)'(s1_n_ff) * (2*K_W)'(s1_n_ff);
         // cubes and mixed terms
         s3_ctrl_ff <= s2_ctrl_ff;
         s3_pts_ff  <= s2_pts_ff;
         s3_u3_ff   <= W_W'(s2_u2_ff) * W_W'(s2_u_ff);
         s3_m1_ff   <= W_W'(s2_u2_ff) * W_W'(s2_k_ff);
         s3_m2_ff   <= W_W'(s2_k2_ff) * W_W'(s2_u_ff);
         s3_k3_ff   <= W_W'(s2_k2_ff) * W_W'(s2_k_ff);
         s3_d_ff    <= W_W'(s2_n2_ff) * W_W'(s2_n_ff);
         // bernstein weights, divisor and rounding bias
         s4_ctrl_ff <= s3_ctrl_ff;
         s4_pts_ff  <= s3_pts_ff;
         s4_w0_ff   <= s3_u3_ff;
         s4_w1_ff   <= s3_m1_ff + (s3_m1_ff << 1);
         s4_w2_ff   <= s3_m2_ff + (s3_m2_ff << 1) + s3_k3_ff;
         s4_dd_ff   <= {s3_d_ff, 1'b0};
         s4_bias_ff <= NUM_W'(s3_d_ff) + (NUM_W'(s3_d_ff) << (FRAC_BITS + 16));
         // weighted coordinates
         s5_ctrl_ff <= s4_ctrl_ff;
         s5_dd_ff   <= s4_dd_ff;
         s5_bias_ff <= s4_bias_ff;
         s5_px0_ff  <= P_W'($signed({1'b0, s4_w0_ff})) * P_W'(s4_pts_ff.start_x);
         s5_px1_ff  <= P_W'($signed({1'b0, s4_w1_ff})) * P_W'(s4_pts_ff.control_x);
         s5_px2_ff  <= P_W'($signed({1'b0, s4_w2_ff})) * P_W'(s4_pts_ff.end_x);
         s5_py0_ff  <= P_W'($signed({1'b0, s4_w0_ff})) * P_W'(s4_pts_ff.start_y);
         s5_py1_ff  <= P_W'($signed({1'b0, s4_w1_ff})) * P_W'(s4_pts_ff.control_y);
         s5_py2_ff  <= P_W'($signed({1'b0, s4_w2_ff})) * P_W'(s4_pts_ff.end_y);
         // sums
         s6_ctrl_ff <= s5_ctrl_ff;
         s6_dd_ff   <= s5_dd_ff;
         s6_bias_ff <= s5_bias_ff;
         s6_sx_ff   <= S_W'(s5_px0_ff) + S_W'(s5_px1_ff) + S_W'(s5_px2_ff);
         s6_sy_ff   <= S_W'(s5_py0_ff) + S_W'(s5_py1_ff) + S_W'(s5_py2_ff);
         // scaled, biased numerators
         s7_ctrl_ff <= s6_ctrl_ff;
         s7_dd_ff   <= s6_dd_ff;
         s7_vx_ff   <= vx_in[NUM_W-1:0];
         s7_vy_ff   <= vy_in[NUM_W-1:0];
      end
   end

   // division
   bcs_ctrl_type     div_ctrl;
   logic [QUO_W-1:0] div_qx;
   logic [QUO_W-1:0] div_qy;

   bcs_divider #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W),
      .QUO_W(QUO_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_ctrl   (s7_ctrl_ff),
      .in_num_x  (s7_vx_ff),
      .in_num_y  (s7_vy_ff),
      .in_den    (s7_dd_ff),
      .out_ctrl  (div_ctrl),
      .out_quo_x (div_qx),
      .out_quo_y (div_qy)
   );

   // unbias, saturate, pair with previous sample
   logic signed [RES_W-1:0] rx, ry;
   logic signed [OUT_W-1:0] prev_x_ff, prev_y_ff;
   bcs_rsp_type             fin_data;
   logic                    fin_push;

   assign rx       = $signed({5'b0, div_qx} - Q_BIAS);
   assign ry       = $signed({5'b0, div_qy} - Q_BIAS);
   assign fin_push = pipe_en && div_ctrl.valid;

   always_comb begin
      fin_data.to_x    = bcs_sat(32'(rx));
      fin_data.to_y    = bcs_sat(32'(ry));
      fin_data.is_last = div_ctrl.last;
      if (div_ctrl.first) begin
         fin_data.from_x = bcs_sat(32'(div_ctrl.start_x) <<< FRAC_BITS);
         fin_data.from_y = bcs_sat(32'(div_ctrl.start_y) <<< FRAC_BITS);
      end else begin
         fin_data.from_x = prev_x_ff;
         fin_data.from_y = prev_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_push) begin
         prev_x_ff <= fin_data.to_x;
         prev_y_ff <= fin_data.to_y;
      end
   end

   // output register and skid
   logic        rsp_valid_ff;
   bcs_rsp_type rsp_data_ff;
   bcs_rsp_type skid_data_ff;
   logic        rsp_take;

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_take) begin
            rsp_data_ff  <= skid_data_ff;
            skid_full_ff <= 1'b0;
         end
      end else if (fin_push) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_ff  <= fin_data;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_data_ff <= fin_data;
            skid_full_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   logic seq_k_ok;

   assign seq_k_ok = (seq_k_ff >= K_W'(1)) && (seq_k_ff <= seq_n_ff);

   `BCS_ASSERT_NOW(a_skid_behind_out, skid_full_ff, rsp_valid_ff, "skid item without output item")
   `BCS_ASSERT_NOW(a_seq_in_range, seq_busy_ff, seq_k_ok, "sample index outside curve")
   `BCS_ASSERT_NEXT(a_new_curve_start, req_take, seq_busy_ff && seq_k_ff == K_W'(1), "no restart")

endmodule

### tb/sv/tb.sv
// self-checking testbench for the bezier curve segmenter
`timescale 1ns / 1ps

module tb;
   import bcs_pkg::*;

   localparam int FRAC_BITS    = 4;
   localparam int MAX_SEGMENTS = 64;
   localparam longint SCALE    = longint'(1) << FRAC_BITS;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE       = FRAC_BITS + 40;
   localparam int RAND_CURVES  = 17;

   typedef struct {
      bit         set_count;
      logic [6:0] count;
      int         sx, sy, cx, cy, ex, ey;
      bit         typed;
      int         tx, ty, tn;
   } curve_row_type;

   localparam int PLAN_LEN = 14;

   curve_row_type plan [0:PLAN_LEN-1] = '{
      '{0, 7'd0,        0,      0,      0,      0,      0,      0, 1,       0,       0, 25},
      '{0, 7'd0,    32767,  32767,  32767,  32767,  32767,  32767, 1,  524272,  524272, 25},
      '{0, 7'd0,   -32768, -32768, -32768, -32768, -32768, -32768, 1, -524288, -524288, 25},
      '{0, 7'd0,   -32768,  32767,  32767, -32768,  32767, -32768, 0,       0,       0,  0},
      '{1, 7'd0,   -32768,  32767,      0,      0,  32767, -32768, 0,       0,       0,  0},
      '{1, 7'd127, -32768, -32768,  32767,  32767, -32768, -32768, 0,       0,       0,  0},
      '{1, 7'd65,    1234,  -4321,   1234,  -4321,   1234,  -4321, 1,   19744,  -69136, 64},
      '{1, 7'd64,   32767, -32768, -32768,  32767,  32767,  32767, 0,       0,       0,  0},
      '{1, 7'd1,      100,   -100,   5000,  -5000, -32768,  32767, 0,       0,       0,  0},
      '{1, 7'd2,        1,     -1,      0,      0,      0,      0, 0,       0,       0,  0},
      '{1, 7'd32,       0,      0,      0,      0,    512,   -512, 0,       0,       0,  0},
      '{0, 7'd32,      -7,     13,  29999, -29999,     -1,      1, 0,       0,       0,  0},
      '{1, 7'd3,    21845, -21846,  21845, -21846,  21845, -21846, 0,       0,       0,  0},
      '{1, 7'd25,  -21846,  21845, -21846,  21845, -21846,  21845, 0,       0,       0,  0}
   };

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bcs_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bcs_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_wdata = '0;

   bcs_rsp_type segment_queue [$];
   logic [6:0]  segment_count = SEG_RESET;
   int          tx_pct = 0;
   int          rx_pct = 0;
   int          fault_count = 0;
   int          cycle_count = 0;

   bezier_curve_segmenter #(
      .MAX_SEGMENTS(MAX_SEGMENTS),
      .FRAC_BITS   (FRAC_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // exact sample k of n, rounded half up, saturated to 20 bits
   function automatic logic signed [19:0] curve_coord(longint s, longint c, longint e,
                                                      longint k, longint n);
      longint u, d, total, v, q;
      u = n - k;
      d = n * n * n;
      total = u * u * u * s + 3 * u * u * k * c + 3 * u * k * k * e + k * k * k * e;
      v = 2 * SCALE * total + d + 2 * SCALE * 32768 * d;
      q = v / (2 * d) - SCALE * 32768;
      if (q > 524287) begin
         q = 524287;
      end else if (q < -524288) begin
         q = -524288;
      end
      return q[19:0];
   endfunction

   function automatic int effective_count(logic [6:0] count);
      if (count == 0) begin
         return 1;
      end else if (count > MAX_SEGMENTS) begin
         return MAX_SEGMENTS;
      end
      return int'(count);
   endfunction

   task automatic predict_segments(bcs_req_type pts);
      int          n;
      bcs_rsp_type seg;
      logic signed [19:0] px, py;
      n  = effective_count(segment_count);
      px = curve_coord(pts.start_x, pts.control_x, pts.end_x, 0, n);
      py = curve_coord(pts.start_y, pts.control_y, pts.end_y, 0, n);
      for (int k = 1; k <= n; k++) begin
         seg.from_x  = px;
         seg.from_y  = py;
         seg.to_x    = curve_coord(pts.start_x, pts.control_x, pts.end_x, k, n);
         seg.to_y    = curve_coord(pts.start_y, pts.control_y, pts.end_y, k, n);
         seg.is_last = (k == n);
         px = seg.to_x;
         py = seg.to_y;
         segment_queue = {segment_queue, seg};
      end
   endtask

   // degenerate curve: every segment sits on the one point
   task automatic push_flat_segments(int tx, int ty, int tn);
      bcs_rsp_type seg;
      for (int k = 1; k <= tn; k++) begin
         seg.from_x  = tx[19:0];
         seg.from_y  = ty[19:0];
         seg.to_x    = tx[19:0];
         seg.to_y    = ty[19:0];
         seg.is_last = (k == tn);
         segment_queue = {segment_queue, seg};
      end
   endtask

   task automatic send_curve(bcs_req_type pts);
      while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pts;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (segment_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_count(logic [6:0] value);
      req_valid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid     <= 1'b0;
      segment_count = value;
   endtask

   function automatic logic signed [15:0] random_coord();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [6:0] random_count();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return 7'($urandom_range(1, 6));
      end else if (pick < 8) begin
         return 7'($urandom_range(7, 64));
      end else if (pick == 8) begin
         return ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd0;
      end
      return 7'($urandom_range(65, 127));
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** bezier_curve_segmenter: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      bcs_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (rx_pct != 0) && ($urandom_range(0, 99) < rx_pct);
         if (rsp_valid && !rsp_stall) begin
            if (segment_queue.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected segment from (%0d,%0d) to (%0d,%0d) last %0b",
                           rsp_data.from_x, rsp_data.from_y, rsp_data.to_x,
                           rsp_data.to_y, rsp_data.is_last);
               end
            end else begin
               want = segment_queue.pop_front();
               if (rsp_data.from_x !== want.from_x || rsp_data.from_y !== want.from_y ||
                   rsp_data.to_x !== want.to_x || rsp_data.to_y !== want.to_y ||
                   rsp_data.is_last !== want.is_last) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("segment mismatch: expected (%0d,%0d)->(%0d,%0d) last %0b,",
                              want.from_x, want.from_y, want.to_x, want.to_y,
                              want.is_last);
                     $display("   got (%0d,%0d)->(%0d,%0d) last %0b",
                              rsp_data.from_x, rsp_data.from_y, rsp_data.to_x,
                              rsp_data.to_y, rsp_data.is_last);
                  end
               end
            end
         end
      end
   end

   initial begin
      bcs_req_type pts;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_pct = 32;
      rx_pct = 88;
      for (int r = 0; r < PLAN_LEN; r++) begin
         if (plan[r].set_count) begin
            write_count(plan[r].count);
         end
         pts.start_x   = plan[r].sx[15:0];
         pts.start_y   = plan[r].sy[15:0];
         pts.control_x = plan[r].cx[15:0];
         pts.control_y = plan[r].cy[15:0];
         pts.end_x     = plan[r].ex[15:0];
         pts.end_y     = plan[r].ey[15:0];
         send_curve(pts);
         if (plan[r].typed) begin
            push_flat_segments(plan[r].tx, plan[r].ty, plan[r].tn);
         end else begin
            predict_segments(pts);
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               tx_pct = 32;
               rx_pct = 88;
            end
            1: begin
               tx_pct = 88;
               rx_pct = 32;
            end
            default: begin
               tx_pct = 0;
               rx_pct = 0;
            end
         endcase
         for (int phase = 0; phase < 4; phase++) begin
            write_count(random_count());
            repeat (RAND_CURVES) begin
               pts.start_x   = random_coord();
               pts.start_y   = random_coord();
               pts.control_x = random_coord();
               pts.control_y = random_coord();
               pts.end_x     = random_coord();
               pts.end_y     = random_coord();
               send_curve(pts);
               predict_segments(pts);
            end
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (segment_queue.size() != 0) begin
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("** bezier_curve_segmenter: PASSED **");
      end else begin
         $display("** bezier_curve_segmenter: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_divider.sv
hw/rtl/bezier_curve_segmenter.sv
tb/sv/tb.sv
